FILE: rtl/core/cmod_pkg.sv
package cmod_pkg;

	localparam int SumW = 27;
	localparam int ColFieldW = 12;
	localparam int CfgAddrW = 4;

	typedef enum logic [1:0] {
		REG_HALF_ROWS = 2'd0,
		REG_ACTIVE_COLS = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_MONO_MODE = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_JUDGE,
		ST_OUT1,
		ST_OUT2
	} state_t;

	typedef struct packed {
		logic bad;
		logic lower_half;
		logic [ColFieldW-1:0] column;
	} flag_t;

endpackage

FILE: rtl/core/cmod_ram.sv
module cmod_ram #(
	parameter int Width = 27,
	parameter int Depth = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/cmod_div.sv
// restoring divider, one quotient bit per cycle
module cmod_div #(
	parameter int DW = 27,
	parameter int VW = 12
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DW-1:0] dividend,
	input logic [VW-1:0] divisor,
	output logic done,
	output logic [DW-1:0] quotient
);

	localparam int CntW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [VW:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(rem_sh - {1'b0, dvs_q}) : VW'(rem_sh);
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/column_mean_outlier_detector_unit.sv
// Flow: a pixel outside the last row of a half is taken in ST_IDLE and summed in ST_READ; one in the last row
// is also divided in the bit-serial divider (ST_DIV), judged (ST_JUDGE) and, unless it is in column 0, sends
// its flag transfers (up to two, ST_OUT1 and ST_OUT2, each held until m_tready) before the next pixel is taken.
// Throughput: one pixel at a time; the column sum memory read-modify-write spans ST_IDLE and ST_READ.
// Reset: counters, the two previous averages and the config registers return to defaults; sums are not cleared.
module column_mean_outlier_detector_unit
	import cmod_pkg::*;
#(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_HALF_ROWS = 2048,
	parameter int PIXEL_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata, // pixel
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata, // column[11:0], lower_half[12], bad[13], zero pad
	output logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CfgAddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int HW = $clog2(MAX_HALF_ROWS + 1);
	localparam int RW = (MAX_HALF_ROWS > 1) ? $clog2(MAX_HALF_ROWS) : 1;
	localparam logic [PIXEL_BITS-1:0] PixMax = '1;

	logic [11:0] half_rows_q;
	logic [12:0] active_cols_q;
	logic [15:0] threshold_q;
	logic mono_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_rows_q <= 12'd2048;
			active_cols_q <= 13'd4096;
			threshold_q <= 16'd64;
			mono_q <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_HALF_ROWS: half_rows_q <= pwdata[11:0];
				REG_ACTIVE_COLS: active_cols_q <= pwdata[12:0];
				REG_THRESHOLD: threshold_q <= pwdata[15:0];
				REG_MONO_MODE: mono_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_HALF_ROWS: prdata = {20'd0, half_rows_q};
			REG_ACTIVE_COLS: prdata = {19'd0, active_cols_q};
			REG_THRESHOLD: prdata = {16'd0, threshold_q};
			REG_MONO_MODE: prdata = {31'd0, mono_q};
			default: prdata = '0;
		endcase
	end

	// effective limits
	logic [HW-1:0] hr_eff;
	logic [CW-1:0] cols_eff;
	logic [AW-1:0] last_col;
	logic [RW-1:0] last_row;
	logic [AW-1:0] col_cnt_q;
	logic [RW-1:0] row_cnt_q;
	logic lower_q;
	logic [AW-1:0] c_in;
	logic [RW-1:0] r_in;

	always_comb begin
		if (half_rows_q == '0) begin
			hr_eff = HW'(1);
		end else if (32'(half_rows_q) > 32'(MAX_HALF_ROWS)) begin
			hr_eff = HW'(MAX_HALF_ROWS);
		end else begin
			hr_eff = HW'(half_rows_q);
		end
		if (active_cols_q < 13'd2) begin
			cols_eff = CW'(2);
		end else if (32'(active_cols_q) > 32'(MAX_COLUMNS)) begin
			cols_eff = CW'(MAX_COLUMNS);
		end else begin
			cols_eff = CW'(active_cols_q);
		end
		last_col = AW'(cols_eff - 1'b1);
		last_row = RW'(hr_eff - 1'b1);
		c_in = (col_cnt_q > last_col) ? last_col : col_cnt_q;
		r_in = (row_cnt_q > last_row) ? last_row : row_cnt_q;
	end

	state_t state_q, state_d;

	logic [PIXEL_BITS-1:0] pix_s1;
	logic [AW-1:0] c_s1;
	logic first_row_s1;
	logic last_row_s1;
	logic last_col_s1;

	logic [SumW-1:0] ram_rdata;
	logic [SumW-1:0] sum_new;
	logic ram_we;
	logic div_done;
	logic [SumW-1:0] div_quo;
	logic [PIXEL_BITS-1:0] avg_q;
	logic [PIXEL_BITS-1:0] avg1_q;
	logic [PIXEL_BITS-1:0] avg2_q;
	flag_t flag_q;
	logic last_q;
	logic valid_q;

	logic in_acc;
	logic advance;
	logic shift_avg;
	logic load1;
	logic load2;
	logic drop;

	assign in_acc = s_tvalid && s_tready;
	assign sum_new = first_row_s1 ? SumW'(pix_s1) : ram_rdata + SumW'(pix_s1);
	assign ram_we = (state_q == ST_READ);

	cmod_ram #(
		.Width(SumW),
		.Depth(MAX_COLUMNS)
	) u_sums (
		.clk(clk),
		.we(ram_we),
		.waddr(c_s1),
		.wdata(sum_new),
		.raddr(c_in),
		.rdata(ram_rdata)
	);

	cmod_div #(
		.DW(SumW),
		.VW(HW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(ram_we && last_row_s1),
		.dividend(sum_new),
		.divisor(hr_eff),
		.done(div_done),
		.quotient(div_quo)
	);

	function automatic logic differs(logic [PIXEL_BITS-1:0] a, logic [PIXEL_BITS-1:0] b,
			logic [15:0] thr);
		logic [PIXEL_BITS-1:0] d;
		d = (a > b) ? a - b : b - a;
		return 32'(d) > 32'(thr);
	endfunction

	logic bad1;
	logic bad2;
	logic right1;

	always_comb begin
		right1 = differs(avg1_q, avg_q, threshold_q);
		bad1 = (c_s1 == AW'(1)) ? right1 : (right1 && differs(avg1_q, avg2_q, threshold_q));
		bad2 = differs(avg_q, avg1_q, threshold_q);
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		advance = 1'b0;
		shift_avg = 1'b0;
		load1 = 1'b0;
		load2 = 1'b0;
		drop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (last_row_s1) begin
					state_d = ST_DIV;
				end else begin
					advance = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_JUDGE;
				end
			end
			ST_JUDGE: begin
				if (c_s1 != '0) begin
					load1 = 1'b1;
					state_d = ST_OUT1;
				end else begin
					shift_avg = 1'b1;
					advance = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_OUT1: begin
				if (m_tready) begin
					if (last_col_s1) begin
						load2 = 1'b1;
						state_d = ST_OUT2;
					end else begin
						drop = 1'b1;
						shift_avg = 1'b1;
						advance = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_OUT2: begin
				if (m_tready) begin
					drop = 1'b1;
					shift_avg = 1'b1;
					advance = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= s_tdata[PIXEL_BITS-1:0];
			c_s1 <= c_in;
			first_row_s1 <= (r_in == '0);
			last_row_s1 <= (r_in == last_row);
			last_col_s1 <= (c_in == last_col);
		end
		if (div_done) begin
			avg_q <= (div_quo > SumW'(PixMax)) ? PixMax : div_quo[PIXEL_BITS-1:0];
		end
		if (load1) begin
			flag_q.column <= ColFieldW'(c_s1 - 1'b1);
			flag_q.lower_half <= lower_q;
			flag_q.bad <= mono_q && bad1;
			last_q <= 1'b0;
		end else if (load2) begin
			flag_q.column <= ColFieldW'(c_s1);
			flag_q.lower_half <= lower_q;
			flag_q.bad <= mono_q && bad2;
			last_q <= lower_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			lower_q <= 1'b0;
			avg1_q <= '0;
			avg2_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load1) begin
				valid_q <= 1'b1;
			end else if (drop) begin
				valid_q <= 1'b0;
			end
			if (shift_avg) begin
				avg2_q <= avg1_q;
				avg1_q <= avg_q;
			end
			if (advance) begin
				if (last_col_s1) begin
					col_cnt_q <= '0;
					if (last_row_s1) begin
						row_cnt_q <= '0;
						lower_q <= ~lower_q;
					end else begin
						row_cnt_q <= RW'(r_in + 1'b1);
					end
				end else begin
					col_cnt_q <= AW'(c_s1 + 1'b1);
					row_cnt_q <= r_in;
				end
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {2'b00, flag_q};
	assign m_tlast = last_q;

endmodule

FILE: rtl/core/cmod_checker.sv
module cmod_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata,
	input logic m_tlast,
	input logic pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("pixel taken while previous one in work");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input open while a flag waits");

	a_last_lower: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[12])
		else $error("frame end flagged in upper half");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind column_mean_outlier_detector_unit cmod_checker u_cmod_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast),
	.pready(pready)
);

FILE: bench/column_mean_outlier_detector_unit_test.sv
module column_mean_outlier_detector_unit_test;
	import cmod_pkg::*;

	typedef struct {
		flag_t f;
		logic last;
	} col_flag_t;

	class flag_board;
		int unsigned half_rows_reg;
		int unsigned cols_reg;
		int unsigned thresh_reg;
		bit mono_reg;
		bit [SumW-1:0] col_sum[4096];
		int unsigned row_cnt;
		int unsigned col_cnt;
		bit lower;
		bit [15:0] avg_prev2;
		bit [15:0] avg_prev1;
		col_flag_t flags_due[$];
		int errors;

		function new();
			half_rows_reg = 2048;
			cols_reg = 4096;
			thresh_reg = 64;
			mono_reg = 1;
			row_cnt = 0;
			col_cnt = 0;
			lower = 0;
			avg_prev2 = 0;
			avg_prev1 = 0;
			errors = 0;
		endfunction

		function int unsigned eff_rows();
			if (half_rows_reg < 1) return 1;
			if (half_rows_reg > 2048) return 2048;
			return half_rows_reg;
		endfunction

		function int unsigned eff_cols();
			if (cols_reg < 2) return 2;
			if (cols_reg > 4096) return 4096;
			return cols_reg;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_HALF_ROWS: half_rows_reg = v[11:0];
				REG_ACTIVE_COLS: cols_reg = v[12:0];
				REG_THRESHOLD: thresh_reg = v[15:0];
				REG_MONO_MODE: mono_reg = v[0];
				default: ;
			endcase
		endfunction

		function bit far_apart(bit [15:0] a, bit [15:0] b);
			int unsigned d;
			d = (a > b) ? a - b : b - a;
			return d > thresh_reg;
		endfunction

		function void push_flag(int unsigned c, bit bad, bit last);
			col_flag_t e;
			e.f.column = c[11:0];
			e.f.lower_half = lower;
			e.f.bad = mono_reg ? bad : 1'b0;
			e.last = last;
			flags_due.push_back(e);
		endfunction

		function void note_pixel(logic [15:0] p);
			int unsigned hr, nc, c, r;
			int unsigned avg;
			bit right, bad;
			hr = eff_rows();
			nc = eff_cols();
			c = (col_cnt > nc - 1) ? nc - 1 : col_cnt;
			r = (row_cnt > hr - 1) ? hr - 1 : row_cnt;
			if (r == 0)
				col_sum[c] = SumW'(p);
			else
				col_sum[c] = col_sum[c] + SumW'(p);
			if (r == hr - 1) begin
				avg = col_sum[c] / hr;
				if (avg > 65535) avg = 65535;
				if (c > 0) begin
					right = far_apart(avg_prev1, avg[15:0]);
					bad = (c == 1) ? right : (right && far_apart(avg_prev1, avg_prev2));
					push_flag(c - 1, bad, 1'b0);
					if (c == nc - 1)
						push_flag(c, far_apart(avg[15:0], avg_prev1), lower);
				end
				avg_prev2 = avg_prev1;
				avg_prev1 = avg[15:0];
			end
			if (c == nc - 1) begin
				col_cnt = 0;
				if (r == hr - 1) begin
					row_cnt = 0;
					lower = !lower;
				end else begin
					row_cnt = r + 1;
				end
			end else begin
				col_cnt = c + 1;
				row_cnt = r;
			end
		endfunction

		function void check_flag(logic [15:0] d, logic last);
			col_flag_t e;
			if (flags_due.size() == 0) begin
				$display("%0t: unexpected flag transfer, actual tdata=%h tlast=%b", $time, d, last);
				errors++;
				return;
			end
			e = flags_due.pop_front();
			if (d[11:0] !== e.f.column) begin
				$display("%0t: column expected %0d actual %0d", $time, e.f.column, d[11:0]);
				errors++;
			end
			if (d[12] !== e.f.lower_half) begin
				$display("%0t: lower_half expected %b actual %b", $time, e.f.lower_half, d[12]);
				errors++;
			end
			if (d[13] !== e.f.bad) begin
				$display("%0t: bad expected %b actual %b (column %0d)", $time, e.f.bad, d[13],
					e.f.column);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last expected %b actual %b", $time, e.last, last);
				errors++;
			end
			if (d[15:14] !== 2'b00) begin
				$display("%0t: pad expected 0 actual %b", $time, d[15:14]);
				errors++;
			end
		endfunction

		function int pending();
			return flags_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata; // pixel
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata; // column[11:0], lower_half[12], bad[13], zero pad
	logic m_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CfgAddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	flag_board sb = new();
	int cycle_cnt = 0;
	int idle_cnt = 0;
	int flags_seen = 0;
	bit calm = 0;
	bit [15:0] col_level[4096];

	column_mean_outlier_detector_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		calm <= (cycle_cnt >= 3000 && cycle_cnt < 9000);
		if (s_tvalid && s_tready)
			sb.note_pixel(s_tdata);
		if (m_tvalid && m_tready) begin
			sb.check_flag(m_tdata, m_tlast);
			flags_seen <= flags_seen + 1;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		bit held;
		held = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && flags_seen >= 60) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	task automatic set_frame(logic [31:0] hr, logic [31:0] nc, logic [31:0] thr, logic mono);
		reg_write(REG_HALF_ROWS, hr);
		reg_write(REG_ACTIVE_COLS, nc);
		reg_write(REG_THRESHOLD, thr);
		reg_write(REG_MONO_MODE, {31'd0, mono});
	endtask

	task automatic send_pixel(logic [15:0] p);
		while (!calm && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] make_pixel();
		int unsigned c, v;
		c = sb.col_cnt;
		if (c > 4095) c = 4095;
		if ($urandom_range(0, 99) < 15) return 16'($urandom_range(0, 65535));
		v = col_level[c] + $urandom_range(0, 7);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	task automatic random_levels(int unsigned spread);
		int unsigned base;
		base = $urandom_range(0, 65535 - spread);
		foreach (col_level[i])
			col_level[i] = 16'(($urandom_range(0, 99) < 20) ? base + $urandom_range(0, spread)
				: base);
	endtask

	initial begin
		int rand_items, npix;
		logic [31:0] hr, nc, thr;
		logic [15:0] dir_a[10];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// zero rows/cols clamp up, zero threshold
		set_frame(0, 0, 0, 1'b1);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		drain();
		// inner and edge outliers
		dir_a = '{100, 500, 100, 100, 100, 0, 0, 0, 0, 65535};
		set_frame(1, 5, 100, 1'b1);
		foreach (dir_a[i]) send_pixel(dir_a[i]);
		drain();
		// colour mode: flags forced low
		reg_write(REG_MONO_MODE, 0);
		for (int i = 0; i < 5; i++) send_pixel(dir_a[i]);
		drain();
		// column counter beyond a shrunk width
		set_frame(1, 4, 65535, 1'b1);
		send_pixel(16'h5555);
		send_pixel(16'hAAAA);
		drain();
		reg_write(REG_ACTIVE_COLS, 2);
		send_pixel(16'h1234);
		send_pixel(16'hFEDC);
		drain();

		rand_items = 0;
		while (rand_items < 500) begin
			hr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			nc = $urandom_range(0, 12);
			case ($urandom_range(0, 3))
				0: thr = 0;
				1: thr = 65535;
				2: thr = $urandom_range(0, 65535);
				default: thr = $urandom_range(0, 200);
			endcase
			sb.half_rows_reg = sb.half_rows_reg;
			if ((sb.row_cnt != 0 || sb.col_cnt != 0) &&
				((nc < 2 ? 2 : nc) > sb.eff_cols()))
				nc = sb.cols_reg;
			set_frame(hr, nc, thr, $urandom_range(0, 5) != 0);
			random_levels($urandom_range(0, 3) == 0 ? 65535 : 400);
			if ($urandom_range(0, 4) == 0)
				npix = $urandom_range(1, 20);
			else
				npix = 2 * sb.eff_rows() * sb.eff_cols() * $urandom_range(1, 2);
			if (sb.row_cnt == 0 && sb.col_cnt == 0 && $urandom_range(0, 1) == 0)
				npix = npix;
			for (int i = 0; i < npix; i++) send_pixel(make_pixel());
			rand_items += npix;
			drain();
		end

		// largest sizes, clamped from out-of-range register values
		if (sb.row_cnt != 0 || sb.col_cnt != 0) begin
			reg_write(REG_ACTIVE_COLS, sb.cols_reg);
			for (int i = 0; sb.row_cnt != 0 || sb.col_cnt != 0; i++)
				send_pixel(make_pixel());
			drain();
		end
		random_levels(65535);
		set_frame(1, 8191, $urandom_range(0, 2000), 1'b1);
		for (int i = 0; i < 300; i++) send_pixel(make_pixel());
		drain();
		set_frame(4095, 2, 64, 1'b1);
		for (int i = 0; i < 200; i++) send_pixel(make_pixel());
		drain();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/cmod_pkg.sv
rtl/core/cmod_ram.sv
rtl/core/cmod_div.sv
rtl/core/column_mean_outlier_detector_unit.sv
rtl/core/cmod_checker.sv
bench/column_mean_outlier_detector_unit_test.sv
